/* rtl/rrfsa_pkg.sv */
// Shared types and constants for the round-robin free server allocator.
// Used by the front end, the command queue, the back end and the top level.
package rrfsa_pkg;

    // sizing
    localparam int NUM_SERVERS  = 8;
    localparam int NUM_REQUESTS = 256;
    localparam int LOAD_BITS    = 32;

    localparam int SRV_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int REQ_W = (NUM_REQUESTS > 1) ? $clog2(NUM_REQUESTS) : 1;

    // stream field widths
    localparam int CFG_W    = 4;
    localparam int KIND_W   = 1;
    localparam int ID_W     = 8;
    localparam int LEN_W    = 16;
    localparam int SERVER_W = 3;
    localparam int MLOAD_W  = 32;
    localparam int MMASK_W  = 8;

    localparam int IN_W      = ID_W + LEN_W;
    localparam int IN_DATA_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W     = 1 + SERVER_W + 1 + MLOAD_W + MMASK_W;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int OUT_PAD_W = OUT_DATA_W - OUT_W;

    // saturating load arithmetic
    localparam int SUM_W = ((LOAD_BITS > LEN_W) ? LOAD_BITS : LEN_W) + 1;
    localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;

    // active server register
    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(8);

    // command queue
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        OP_ARRIVE   = 1'b0,
        OP_COMPLETE = 1'b1
    } op_t;

    // classified event handed from front to back
    typedef struct packed {
        op_t               op;
        logic              id_ok;
        logic [REQ_W-1:0]  idx;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_PEAK,
        ST_SEND
    } state_t;

endpackage

/* rtl/round_robin_free_server_allocator.sv */
// Channel   Direction  Signals                     Contents (lowest bit first)
// s_        in         s_tvalid/s_tready/s_tdata   request_id[7:0], work_length[15:0]
//                      s_tuser                     kind (0 arrive, 1 complete)
// m_        out        m_tvalid/m_tready/m_tdata   granted, server[2:0], released,
//                                                  max_load[31:0], max_mask[7:0]
// cfg_      in         cfg_wr_en/cfg_wr_data       active_servers[3:0]
//
// Each event passes through the back end in these steps:
// dequeue, owner table read, update, a one-server-per-cycle sweep for the peak load, then send.
// Reset is synchronous and active low; owner valid bits clear at once, no clearing pass.
// A two-entry queue lets the front keep taking transfers while the back end works,
// and the output register lets the next event run while a result waits on m_tready.
// Top level of the allocator; depends on rrfsa_pkg, rrfsa_front, rrfsa_fifo, rrfsa_back.
module round_robin_free_server_allocator
    import rrfsa_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_W-1:0]       cfg_wr_data,  // active_servers
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,      // request_id[7:0], work_length[23:8]
    input  logic [KIND_W-1:0]      s_tuser,      // kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata       // granted, server, released, max_load, max_mask
);

    logic [CFG_W-1:0]       active_reg;
    logic [CFG_W-1:0]       active_next;
    logic [NUM_SERVERS-1:0] active_mask;
    logic [31:0]            active_cnt;
    logic                   push_valid;
    logic                   push_ready;
    cmd_t                   push_data;
    logic                   pop_valid;
    logic                   pop_ready;
    cmd_t                   pop_data;

    // active server register
    always_comb begin
        active_next = active_reg;
        if (cfg_wr_en) begin
            active_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_RESET;
        end else begin
            active_reg <= active_next;
        end
    end

    // clamp the count to one..NUM_SERVERS and expand to a mask
    always_comb begin
        if (active_reg == '0) begin
            active_cnt = 32'd1;
        end else if (32'(active_reg) > 32'(NUM_SERVERS)) begin
            active_cnt = 32'(NUM_SERVERS);
        end else begin
            active_cnt = 32'(active_reg);
        end
        for (int s = 0; s < NUM_SERVERS; s++) begin
            active_mask[s] = (32'(s) < active_cnt);
        end
    end

    rrfsa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rrfsa_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rrfsa_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .active_mask (active_mask),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

/* rtl/rrfsa_front.sv */
// Front end: takes input transfers, classifies the event and range-checks the id.
// Depends on rrfsa_pkg; feeds rrfsa_fifo.
module rrfsa_front
    import rrfsa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  push_valid,
    input  logic                  push_ready,
    output cmd_t                  push_data
);

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_reg;
    logic [ID_W-1:0] id;

    assign id         = s_tdata[ID_W-1:0];
    assign s_tready   = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_data  = hold_reg;

    // hold register occupancy
    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (push_ready) begin
            hold_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // classify the event on the way in
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            hold_reg.op    <= op_t'(s_tuser);
            hold_reg.id_ok <= (32'(id) < 32'(NUM_REQUESTS));
            hold_reg.idx   <= REQ_W'(id);
            hold_reg.len   <= s_tdata[ID_W +: LEN_W];
        end
    end

endmodule

/* rtl/rrfsa_fifo.sv */
// Short command queue between the front and back ends.
// Depends on rrfsa_pkg for the command type and depth.
module rrfsa_fifo
    import rrfsa_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  cmd_t  push_data,
    output logic  pop_valid,
    input  logic  pop_ready,
    output cmd_t  pop_data
);

    cmd_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_PW-1:0] wr_ptr_reg;
    logic [FIFO_PW-1:0] wr_ptr_next;
    logic [FIFO_PW-1:0] rd_ptr_reg;
    logic [FIFO_PW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != FIFO_CW'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/rrfsa_back.sv */
// Back end: owner table, round-robin grant, load accounting and peak sweep.
// Depends on rrfsa_pkg; drains rrfsa_fifo and holds the output register.
module rrfsa_back
    import rrfsa_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [NUM_SERVERS-1:0] active_mask,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  cmd_t                   pop_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [SRV_W-1:0]        own_srv_reg;
    logic                    own_vld_reg;
    logic [NUM_SERVERS-1:0]  free_reg, free_next;
    logic [SRV_W-1:0]        last_reg, last_next;
    logic [NUM_REQUESTS-1:0] valid_reg, valid_next;
    logic [LOAD_BITS-1:0]    load_reg  [NUM_SERVERS];
    logic [LOAD_BITS-1:0]    load_next [NUM_SERVERS];
    logic [SRV_W-1:0]        k_reg, k_next;
    logic [LOAD_BITS-1:0]    best_reg, best_next;
    logic [NUM_SERVERS-1:0]  bmask_reg, bmask_next;
    logic                    granted_reg, granted_next;
    logic [SRV_W-1:0]        server_reg, server_next;
    logic                    released_reg, released_next;
    logic                    m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]   m_data_reg, m_data_next;

    logic [SRV_W-1:0]        owner_mem [NUM_REQUESTS];
    logic                    owner_we;

    logic [NUM_SERVERS-1:0]  cand;
    logic [NUM_SERVERS-1:0]  cand_hi;
    logic [SRV_W-1:0]        pick_hi;
    logic [SRV_W-1:0]        pick_lo;
    logic [SRV_W-1:0]        pick;
    logic [SUM_W-1:0]        sum;
    logic [LOAD_BITS-1:0]    sat_load;

    assign pop_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // rotating priority pick: first free active server above the last grant, else the lowest free active one
    always_comb begin
        cand    = free_reg & active_mask;
        cand_hi = '0;
        pick_hi = '0;
        pick_lo = '0;
        for (int s = 0; s < NUM_SERVERS; s++) begin
            cand_hi[s] = cand[s] && (SRV_W'(s) > last_reg);
        end
        for (int s = NUM_SERVERS - 1; s >= 0; s--) begin
            if (cand_hi[s]) begin
                pick_hi = SRV_W'(s);
            end
            if (cand[s]) begin
                pick_lo = SRV_W'(s);
            end
        end
        pick = (|cand_hi) ? pick_hi : pick_lo;
    end

    // saturating load add for the picked server
    always_comb begin
        sum      = SUM_W'(load_reg[pick]) + SUM_W'(cmd_reg.len);
        sat_load = (sum > SUM_W'(LOAD_MAX)) ? LOAD_MAX : LOAD_BITS'(sum);
    end

    // sequencer: next state and datapath updates
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        free_next     = free_reg;
        last_next     = last_reg;
        valid_next    = valid_reg;
        load_next     = load_reg;
        k_next        = k_reg;
        best_next     = best_reg;
        bmask_next    = bmask_reg;
        granted_next  = granted_reg;
        server_next   = server_reg;
        released_next = released_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        owner_we      = 1'b0;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    cmd_next   = pop_data;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                granted_next  = 1'b0;
                released_next = 1'b0;
                server_next   = '0;
                if (cmd_reg.op == OP_COMPLETE) begin
                    if (cmd_reg.id_ok && own_vld_reg) begin
                        free_next[own_srv_reg] = 1'b1;
                        valid_next[cmd_reg.idx] = 1'b0;
                        released_next = 1'b1;
                    end
                end else if (cmd_reg.id_ok && (|cand)) begin
                    load_next[pick]         = sat_load;
                    owner_we                = 1'b1;
                    valid_next[cmd_reg.idx] = 1'b1;
                    free_next[pick]         = 1'b0;
                    last_next               = pick;
                    granted_next            = 1'b1;
                    server_next             = pick;
                end
                k_next     = '0;
                best_next  = '0;
                bmask_next = '0;
                state_next = ST_PEAK;
            end
            ST_PEAK: begin
                if (active_mask[k_reg]) begin
                    if (load_reg[k_reg] > best_reg) begin
                        best_next         = load_reg[k_reg];
                        bmask_next        = '0;
                        bmask_next[k_reg] = 1'b1;
                    end else if (load_reg[k_reg] == best_reg) begin
                        bmask_next[k_reg] = 1'b1;
                    end
                end
                if (k_reg == SRV_W'(NUM_SERVERS - 1)) begin
                    state_next = ST_SEND;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_SEND: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {OUT_PAD_W'(0),
                                    MMASK_W'(bmask_reg),
                                    MLOAD_W'(best_reg),
                                    released_reg,
                                    SERVER_W'(server_reg),
                                    granted_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            free_reg    <= '1;
            last_reg    <= SRV_W'(NUM_SERVERS - 1);
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int s = 0; s < NUM_SERVERS; s++) begin
                load_reg[s] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            free_reg    <= free_next;
            last_reg    <= last_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            load_reg    <= load_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        k_reg        <= k_next;
        best_reg     <= best_next;
        bmask_reg    <= bmask_next;
        granted_reg  <= granted_next;
        server_reg   <= server_next;
        released_reg <= released_next;
        m_data_reg   <= m_data_next;
    end

    // owner table: one write port, registered read
    always_ff @(posedge aclk) begin
        if (owner_we) begin
            owner_mem[cmd_reg.idx] <= pick;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_READ) begin
            own_srv_reg <= owner_mem[cmd_reg.idx];
            own_vld_reg <= valid_reg[cmd_reg.idx];
        end
    end

endmodule
